// ===== src/wps_pkg.sv =====
// Shared types, codes and constants for the wheel prime sieve block.
`timescale 1ns / 1ps
package wps_pkg;

  localparam int unsigned MAX_LIMIT_DEF   = 65535;
  localparam int unsigned SIEVE_DEPTH_DEF = 21845;
  localparam int unsigned TABLE_DEPTH_DEF = 8192;

  localparam int LIMIT_W = 16;
  localparam int LEN_W   = 15;
  localparam int WHEEL_W = 17;
  localparam int TOTAL_W = 14;
  localparam int VALUE_W = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

  // limit / 3 == (limit * DIV3_MUL) >> DIV3_SHIFT for every 16-bit limit
  localparam logic [LIMIT_W-1:0] DIV3_MUL   = 16'd43691;
  localparam int                 DIV3_SHIFT = 17;

  localparam logic [WHEEL_W-1:0] WHEEL_STEP_INIT  = 17'd8;
  localparam logic [WHEEL_W-1:0] WHEEL_STEPA_INC  = 17'd16;
  localparam logic [WHEEL_W-1:0] WHEEL_STEPB_INC  = 17'd8;
  localparam logic [WHEEL_W-1:0] WHEEL_FA_INIT    = 17'd3;
  localparam logic [WHEEL_W-1:0] WHEEL_FB_INIT    = 17'd7;
  localparam logic [WHEEL_W-1:0] WHEEL_SQ_INIT    = 17'd7;
  localparam logic [WHEEL_W-1:0] WHEEL_INC        = 17'd2;
  localparam logic [WHEEL_W-1:0] WHEEL_FB_LONG    = 17'd6;
  localparam logic [WHEEL_W-1:0] FILL_NUM_INIT    = 17'd5;
  localparam logic [WHEEL_W-1:0] FILL_STEP_SHORT  = 17'd2;
  localparam logic [WHEEL_W-1:0] FILL_STEP_LONG   = 17'd4;
  localparam logic [VALUE_W-1:0] PRIME_TWO        = 16'd2;
  localparam logic [VALUE_W-1:0] PRIME_THREE      = 16'd3;

  localparam logic [1:0] KIND_BUILD = 2'd0;
  localparam logic [1:0] KIND_RANK  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] query_number;
    logic [13:0] search_start;
    logic [12:0] read_position;
  } in_item_t;

  typedef struct packed {
    logic [13:0] prime_total;
    logic [13:0] rank_result;
    logic [15:0] prime_value;
    logic        out_of_range;
  } out_item_t;

  typedef struct packed {
    logic ld_item;
    logic len_mul;
    logic len_set;
    logic clr_wr;
    logic strk_init;
    logic bit_rd;
    logic walk_a_init;
    logic walk_b_init;
    logic walk_wr;
    logic wheel_adv;
    logic fill_init;
    logic tbl_wr2;
    logic tbl_wr3;
    logic fill_rd;
    logic fill_step;
    logic count_set;
    logic rank_rd;
    logic rank_step;
    logic rank_fin;
    logic read_rd;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       clr_lt_len;
    logic       sq_lt_len;
    logic       bit_set;
    logic       k_lt_len;
    logic       fill_go;
    logic       lo_lt_hi;
    logic       lo_lt_cnt;
  } sts_t;

endpackage

// ===== src/wheel_prime_sieve_with_rank_top.sv =====
// Top level of the wheel prime sieve with rank and read queries.
//
//  channel  | signals                          | transfer
//  ---------+----------------------------------+---------------------------
//  in       | in_valid_i, in_ready_o, in_i     | valid and ready both high
//  out      | out_valid_o, out_ready_i, out_o  | valid and ready both high
//  cfg      | cfg_we_i, cfg_wdata_i            | write enable high
//
// Rank item: halving steps of a binary search, plus one more table read if the search ends inside the table.
// Read item: one table read. Other kind: goes straight to the output.
// Build item: clears the sieve entries (limit / 3 of them, at most SIEVE_DEPTH), writes each struck
//   entry and reads the entries back for the fill; all of these share the single sieve memory port.
// Reset clears the controller, the prime count and the limit register (to 65535).
// A finished item waits in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps
module wheel_prime_sieve_with_rank_top #(
  parameter int unsigned MAX_LIMIT   = wps_pkg::MAX_LIMIT_DEF,
  parameter int unsigned SIEVE_DEPTH = wps_pkg::SIEVE_DEPTH_DEF,
  parameter int unsigned TABLE_DEPTH = wps_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  wps_pkg::in_item_t           in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output wps_pkg::out_item_t          out_o,
  input  logic                        cfg_we_i,
  input  logic [wps_pkg::LIMIT_W-1:0] cfg_wdata_i
);

  logic [wps_pkg::LIMIT_W-1:0] limit_q;
  wps_pkg::cmd_t               cmd;
  wps_pkg::sts_t               sts;
  wps_pkg::out_item_t          res;
  wps_pkg::out_item_t          out_q;
  logic                        out_valid_q;
  logic                        out_free;
  logic                        out_ld;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= wps_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_q <= res;
    end
  end

  wps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .out_ld_o   (out_ld),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wps_datapath #(
    .MAX_LIMIT   (MAX_LIMIT),
    .SIEVE_DEPTH (SIEVE_DEPTH),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .in_i    (in_i),
    .limit_i (limit_q),
    .sts_o   (sts),
    .res_o   (res)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while controller still busy");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ld |-> out_free)
    else $error("result loaded over an item not yet taken");

  a_oor_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.out_of_range |-> out_o.prime_value == '0 && out_o.rank_result == '0)
    else $error("out of range read carries a value");

  a_read_no_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.prime_value != '0 |-> out_o.rank_result == '0 && !out_o.out_of_range)
    else $error("read result mixed with rank result");

endmodule

// ===== src/wps_ctrl.sv =====
// Controller state machine sequencing build, rank and read items.
`timescale 1ns / 1ps
module wps_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_free_i,
  output logic          out_ld_o,
  input  wps_pkg::sts_t sts_i,
  output wps_pkg::cmd_t cmd_o
);

  typedef enum logic [18:0] {
    ST_IDLE     = 19'h00001,
    ST_DECODE   = 19'h00002,
    ST_LEN_MUL  = 19'h00004,
    ST_LEN_SET  = 19'h00008,
    ST_CLEAR    = 19'h00010,
    ST_STRK_RD  = 19'h00020,
    ST_STRK_CHK = 19'h00040,
    ST_WALK_A   = 19'h00080,
    ST_WALK_B   = 19'h00100,
    ST_ADV      = 19'h00200,
    ST_FILL2    = 19'h00400,
    ST_FILL3    = 19'h00800,
    ST_FILL_RD  = 19'h01000,
    ST_FILL_CHK = 19'h02000,
    ST_RANK_CHK = 19'h04000,
    ST_RANK_CMP = 19'h08000,
    ST_RANK_FIN = 19'h10000,
    ST_READ_RD  = 19'h20000,
    ST_DONE     = 19'h40000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_ld_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_item = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.kind)
          wps_pkg::KIND_BUILD: state_d = ST_LEN_MUL;
          wps_pkg::KIND_RANK:  state_d = ST_RANK_CHK;
          wps_pkg::KIND_READ:  state_d = ST_READ_RD;
          default:             state_d = ST_DONE;
        endcase
      end
      ST_LEN_MUL: begin
        cmd_o.len_mul = 1'b1;
        state_d       = ST_LEN_SET;
      end
      ST_LEN_SET: begin
        cmd_o.len_set = 1'b1;
        state_d       = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (sts_i.clr_lt_len) begin
          cmd_o.clr_wr = 1'b1;
        end else begin
          cmd_o.strk_init = 1'b1;
          state_d         = ST_STRK_RD;
        end
      end
      ST_STRK_RD: begin
        if (sts_i.sq_lt_len) begin
          cmd_o.bit_rd = 1'b1;
          state_d      = ST_STRK_CHK;
        end else begin
          cmd_o.fill_init = 1'b1;
          state_d         = ST_FILL2;
        end
      end
      ST_STRK_CHK: begin
        if (sts_i.bit_set) begin
          state_d = ST_ADV;
        end else begin
          cmd_o.walk_a_init = 1'b1;
          state_d           = ST_WALK_A;
        end
      end
      ST_WALK_A: begin
        if (sts_i.k_lt_len) begin
          cmd_o.walk_wr = 1'b1;
        end else begin
          cmd_o.walk_b_init = 1'b1;
          state_d           = ST_WALK_B;
        end
      end
      ST_WALK_B: begin
        if (sts_i.k_lt_len) begin
          cmd_o.walk_wr = 1'b1;
        end else begin
          state_d = ST_ADV;
        end
      end
      ST_ADV: begin
        cmd_o.wheel_adv = 1'b1;
        state_d         = ST_STRK_RD;
      end
      ST_FILL2: begin
        cmd_o.tbl_wr2 = 1'b1;
        state_d       = ST_FILL3;
      end
      ST_FILL3: begin
        cmd_o.tbl_wr3 = 1'b1;
        state_d       = ST_FILL_RD;
      end
      ST_FILL_RD: begin
        if (sts_i.fill_go) begin
          cmd_o.fill_rd = 1'b1;
          state_d       = ST_FILL_CHK;
        end else begin
          cmd_o.count_set = 1'b1;
          state_d         = ST_DONE;
        end
      end
      ST_FILL_CHK: begin
        cmd_o.fill_step = 1'b1;
        state_d         = ST_FILL_RD;
      end
      ST_RANK_CHK: begin
        if (sts_i.lo_lt_hi) begin
          cmd_o.rank_rd = 1'b1;
          state_d       = ST_RANK_CMP;
        end else if (sts_i.lo_lt_cnt) begin
          cmd_o.rank_rd = 1'b1;
          state_d       = ST_RANK_FIN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_RANK_CMP: begin
        cmd_o.rank_step = 1'b1;
        state_d         = ST_RANK_CHK;
      end
      ST_RANK_FIN: begin
        cmd_o.rank_fin = 1'b1;
        state_d        = ST_DONE;
      end
      ST_READ_RD: begin
        cmd_o.read_rd = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) begin
          out_ld_o = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/wps_datapath.sv =====
// Datapath: sieve bit memory, prime table memory, wheel walk and search registers.
`timescale 1ns / 1ps
module wps_datapath #(
  parameter int unsigned MAX_LIMIT   = wps_pkg::MAX_LIMIT_DEF,
  parameter int unsigned SIEVE_DEPTH = wps_pkg::SIEVE_DEPTH_DEF,
  parameter int unsigned TABLE_DEPTH = wps_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wps_pkg::cmd_t                cmd_i,
  input  wps_pkg::in_item_t            in_i,
  input  logic [wps_pkg::LIMIT_W-1:0]  limit_i,
  output wps_pkg::sts_t                sts_o,
  output wps_pkg::out_item_t           res_o
);

  localparam int SAW = (SIEVE_DEPTH > 1) ? $clog2(SIEVE_DEPTH) : 1;
  localparam int TAW = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int RKW = (CW > wps_pkg::TOTAL_W) ? CW : wps_pkg::TOTAL_W;
  localparam int LW  = wps_pkg::LEN_W;
  localparam int WW  = wps_pkg::WHEEL_W;
  localparam int VW  = wps_pkg::VALUE_W;
  localparam int PW  = 2 * wps_pkg::LIMIT_W;

  wps_pkg::in_item_t item_q;

  logic [wps_pkg::LIMIT_W-1:0] lim_q;
  logic [PW-1:0]               prod_q;
  logic [LW-1:0]               len_q, clr_q, pos_q;
  logic [LW-1:0]               quot;

  logic [WW-1:0] stepa_q, stepb_q, fa_q, fb_q, sq_q, off_q, idx_q, k_q, stride_q, num_q;
  logic          phase_q, fphase_q;
  logic [CW-1:0] cnt_q, count_q;
  logic [RKW-1:0] lo_q, hi_q, mid;
  logic [RKW:0]   mid_sum;

  logic           sieve_mem [SIEVE_DEPTH];
  logic           sv_we, sv_re, sv_wdata, sv_rdata_q;
  logic [SAW-1:0] sv_addr;

  logic [VW-1:0]  tbl_mem [TABLE_DEPTH];
  logic           tb_we, tb_re;
  logic [TAW-1:0] tb_addr;
  logic [VW-1:0]  tb_wdata, tb_rdata_q;

  logic rd_in_range;

  assign quot    = prod_q[wps_pkg::DIV3_SHIFT +: LW];
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[RKW:1];

  assign rd_in_range = (32'(item_q.read_position) < 32'(count_q)) &&
                       (32'(item_q.read_position) < 32'(TABLE_DEPTH));

  // sieve memory port
  always_comb begin
    sv_we    = 1'b0;
    sv_re    = 1'b0;
    sv_wdata = 1'b0;
    sv_addr  = '0;
    if (cmd_i.clr_wr) begin
      sv_we   = 1'b1;
      sv_addr = SAW'(clr_q);
    end else if (cmd_i.walk_wr) begin
      sv_we    = 1'b1;
      sv_wdata = 1'b1;
      sv_addr  = SAW'(k_q);
    end else if (cmd_i.bit_rd) begin
      sv_re   = 1'b1;
      sv_addr = SAW'(idx_q);
    end else if (cmd_i.fill_rd) begin
      sv_re   = 1'b1;
      sv_addr = SAW'(pos_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_we) begin
      sieve_mem[sv_addr] <= sv_wdata;
    end
    if (sv_re) begin
      sv_rdata_q <= sieve_mem[sv_addr];
    end
  end

  // prime table port
  always_comb begin
    tb_we    = 1'b0;
    tb_re    = 1'b0;
    tb_wdata = '0;
    tb_addr  = '0;
    if (cmd_i.tbl_wr2) begin
      tb_we    = 1'b1;
      tb_wdata = wps_pkg::PRIME_TWO;
      tb_addr  = TAW'(0);
    end else if (cmd_i.tbl_wr3) begin
      tb_we    = 1'b1;
      tb_wdata = wps_pkg::PRIME_THREE;
      tb_addr  = TAW'(1);
    end else if (cmd_i.fill_step && !sv_rdata_q) begin
      tb_we    = 1'b1;
      tb_wdata = VW'(num_q);
      tb_addr  = TAW'(cnt_q);
    end else if (cmd_i.rank_rd) begin
      tb_re   = 1'b1;
      tb_addr = sts_o.lo_lt_hi ? TAW'(mid) : TAW'(lo_q);
    end else if (cmd_i.read_rd && rd_in_range) begin
      tb_re   = 1'b1;
      tb_addr = TAW'(item_q.read_position);
    end
  end

  always_ff @(posedge clk_i) begin
    if (tb_we) begin
      tbl_mem[tb_addr] <= tb_wdata;
    end
    if (tb_re) begin
      tb_rdata_q <= tbl_mem[tb_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      item_q <= in_i;
      lo_q   <= RKW'(in_i.search_start);
      hi_q   <= RKW'(count_q);
      lim_q  <= (32'(limit_i) > 32'(MAX_LIMIT)) ? wps_pkg::LIMIT_W'(MAX_LIMIT) : limit_i;
    end
    if (cmd_i.len_mul) begin
      prod_q <= PW'(lim_q) * PW'(wps_pkg::DIV3_MUL);
    end
    if (cmd_i.len_set) begin
      len_q <= (32'(quot) > 32'(SIEVE_DEPTH)) ? LW'(SIEVE_DEPTH) : quot;
      clr_q <= '0;
    end
    if (cmd_i.clr_wr) begin
      clr_q <= clr_q + LW'(1);
    end
    if (cmd_i.strk_init) begin
      stepa_q <= wps_pkg::WHEEL_STEP_INIT;
      stepb_q <= wps_pkg::WHEEL_STEP_INIT;
      fa_q    <= wps_pkg::WHEEL_FA_INIT;
      fb_q    <= wps_pkg::WHEEL_FB_INIT;
      sq_q    <= wps_pkg::WHEEL_SQ_INIT;
      off_q   <= wps_pkg::WHEEL_FA_INIT;
      idx_q   <= '0;
      phase_q <= 1'b0;
    end
    if (cmd_i.walk_a_init) begin
      k_q      <= sq_q;
      stride_q <= fa_q + fb_q;
    end
    if (cmd_i.walk_b_init) begin
      k_q <= sq_q + off_q;
    end
    if (cmd_i.walk_wr) begin
      k_q <= k_q + stride_q;
    end
    if (cmd_i.wheel_adv) begin
      idx_q   <= idx_q + WW'(1);
      phase_q <= !phase_q;
      fa_q    <= fa_q + wps_pkg::WHEEL_INC;
      if (!phase_q) begin
        sq_q    <= sq_q + stepb_q;
        stepa_q <= stepa_q + wps_pkg::WHEEL_STEPA_INC;
        fb_q    <= fb_q + wps_pkg::WHEEL_INC;
        off_q   <= fb_q + wps_pkg::WHEEL_INC;
      end else begin
        sq_q    <= sq_q + stepa_q;
        stepb_q <= stepb_q + wps_pkg::WHEEL_STEPB_INC;
        fb_q    <= fb_q + wps_pkg::WHEEL_FB_LONG;
        off_q   <= fa_q + wps_pkg::WHEEL_INC;
      end
    end
    if (cmd_i.fill_init) begin
      pos_q    <= '0;
      num_q    <= wps_pkg::FILL_NUM_INIT;
      cnt_q    <= CW'(2);
      fphase_q <= 1'b0;
    end
    if (cmd_i.fill_step) begin
      if (!sv_rdata_q) begin
        cnt_q <= cnt_q + CW'(1);
      end
      pos_q    <= pos_q + LW'(1);
      fphase_q <= !fphase_q;
      num_q    <= num_q + (fphase_q ? wps_pkg::FILL_STEP_LONG : wps_pkg::FILL_STEP_SHORT);
    end
    if (cmd_i.rank_step) begin
      if (32'(tb_rdata_q) < 32'(item_q.query_number)) begin
        lo_q <= mid + RKW'(1);
      end else begin
        hi_q <= mid;
      end
    end
    if (cmd_i.rank_fin && (tb_rdata_q == item_q.query_number)) begin
      lo_q <= lo_q + RKW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.count_set) begin
      count_q <= cnt_q;
    end
  end

  always_comb begin
    sts_o.kind       = item_q.kind;
    sts_o.clr_lt_len = clr_q < len_q;
    sts_o.sq_lt_len  = sq_q < WW'(len_q);
    sts_o.bit_set    = sv_rdata_q;
    sts_o.k_lt_len   = k_q < WW'(len_q);
    sts_o.fill_go    = (num_q <= WW'(lim_q)) && (pos_q < len_q) &&
                       (32'(cnt_q) < 32'(TABLE_DEPTH));
    sts_o.lo_lt_hi   = lo_q < hi_q;
    sts_o.lo_lt_cnt  = lo_q < RKW'(count_q);
  end

  always_comb begin
    res_o              = '0;
    res_o.prime_total  = wps_pkg::TOTAL_W'(count_q);
    if (item_q.kind == wps_pkg::KIND_RANK) begin
      res_o.rank_result = wps_pkg::TOTAL_W'(lo_q);
    end
    if (item_q.kind == wps_pkg::KIND_READ) begin
      if (rd_in_range) begin
        res_o.prime_value = tb_rdata_q;
      end else begin
        res_o.out_of_range = 1'b1;
      end
    end
  end

endmodule
